/* rtl/ldr_pkg.sv */
package ldr_pkg;

    localparam int QW = 51;
    localparam int FRAC_BITS = 28;

    typedef logic signed [QW-1:0] q_t;

    localparam q_t SAT_MAX = 51'sh3_FFFF_FFFF_FFFF;
    localparam q_t ONE_Q = 51'sd268435456;

    typedef enum logic [2:0] {
        REG_K1    = 3'd0,
        REG_K2    = 3'd1,
        REG_K3    = 3'd2,
        REG_P1    = 3'd3,
        REG_P2    = 3'd4,
        REG_FX    = 3'd5,
        REG_FY    = 3'd6,
        REG_PP    = 3'd7
    } reg_idx_t;

    function automatic q_t sat_add(input q_t a, input q_t b);
        logic signed [QW:0] s;
        logic signed [QW:0] lim;
        s = {a[QW-1], a} + {b[QW-1], b};
        lim = {SAT_MAX[QW-1], SAT_MAX};
        if (s > lim)
            return SAT_MAX;
        else if (s < -lim)
            return -SAT_MAX;
        else
            return s[QW-1:0];
    endfunction

endpackage

/* rtl/ldr_div.sv */
module ldr_div (
    input  logic        clk,
    input  logic        en,
    input  logic [11:0] mag,
    input  logic        neg,
    input  logic [19:0] divisor,
    output logic [47:0] quot,
    output logic        quot_neg
);
    localparam int NW = 48;
    localparam int MW = 12;
    localparam int RW = 21;

    logic [RW-1:0] rem_reg  [NW];
    logic [RW-1:0] rem_next [NW];
    logic [NW-1:0] quo_reg  [NW];
    logic [NW-1:0] quo_next [NW];
    logic [MW-1:0] num_reg  [NW];
    logic [MW-1:0] num_next [NW];
    logic          neg_reg  [NW];
    logic          neg_next [NW];

    always_comb
    begin
        logic [RW-1:0] r;
        logic [NW-1:0] q;
        logic [MW-1:0] n;
        logic          s;
        for (int k = 0; k < NW; k++)
        begin
            if (k == 0)
            begin
                r = '0;
                q = '0;
                n = mag;
                s = neg;
            end
            else
            begin
                r = rem_reg[k-1];
                q = quo_reg[k-1];
                n = num_reg[k-1];
                s = neg_reg[k-1];
            end
            r = {r[RW-2:0], n[MW-1]};
            n = {n[MW-2:0], 1'b0};
            q = {q[NW-2:0], 1'b0};
            if (r >= {1'b0, divisor})
            begin
                r = r - {1'b0, divisor};
                q[0] = 1'b1;
            end
            rem_next[k] = r;
            quo_next[k] = q;
            num_next[k] = n;
            neg_next[k] = s;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < NW; k++)
            begin
                rem_reg[k] <= rem_next[k];
                quo_reg[k] <= quo_next[k];
                num_reg[k] <= num_next[k];
                neg_reg[k] <= neg_next[k];
            end
        end
    end

    assign quot = quo_reg[NW-1];
    assign quot_neg = neg_reg[NW-1];

endmodule

/* rtl/ldr_mul.sv */
module ldr_mul (
    input  logic          clk,
    input  logic          en,
    input  ldr_pkg::q_t   a,
    input  ldr_pkg::q_t   b,
    output ldr_pkg::q_t   p
);
    import ldr_pkg::*;

    localparam int MW = QW - 1;
    localparam int HW = MW / 2;

    logic          neg1_reg;
    logic [MW-1:0] ma_reg;
    logic [MW-1:0] mb_reg;
    logic          neg2_reg;
    logic [2*HW-1:0] ll_reg;
    logic [2*HW-1:0] lh_reg;
    logic [2*HW-1:0] hl_reg;
    logic [2*HW-1:0] hh_reg;
    q_t            p_reg;

    q_t            na;
    q_t            nb;
    logic [2*MW-1:0] full;
    logic [2*MW-FRAC_BITS-1:0] shr;
    logic [MW-1:0] mag;
    q_t            p_next;

    always_comb
    begin
        na = a[QW-1] ? -a : a;
        nb = b[QW-1] ? -b : b;
        full = (2*MW)'(ll_reg)
             + ((2*MW)'(lh_reg) << HW)
             + ((2*MW)'(hl_reg) << HW)
             + ((2*MW)'(hh_reg) << (2*HW));
        shr = full[2*MW-1:FRAC_BITS];
        if (|shr[2*MW-FRAC_BITS-1:MW])
            mag = SAT_MAX[MW-1:0];
        else
            mag = shr[MW-1:0];
        p_next = neg2_reg ? -q_t'({1'b0, mag}) : q_t'({1'b0, mag});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg1_reg <= a[QW-1] ^ b[QW-1];
            ma_reg   <= na[MW-1:0];
            mb_reg   <= nb[MW-1:0];
            neg2_reg <= neg1_reg;
            ll_reg   <= ma_reg[HW-1:0] * mb_reg[HW-1:0];
            lh_reg   <= ma_reg[HW-1:0] * mb_reg[MW-1:HW];
            hl_reg   <= ma_reg[MW-1:HW] * mb_reg[HW-1:0];
            hh_reg   <= ma_reg[MW-1:HW] * mb_reg[MW-1:HW];
            p_reg    <= p_next;
        end
    end

    assign p = p_reg;

endmodule

/* rtl/lens_distortion_remap.sv */
// Brown-Conrady lens distortion remap. Each input beat carries one output pixel
// coordinate; the block returns the source pixel (truncated column and row) to
// sample and an in-bounds flag, with zero indices when the point falls outside
// the IMAGE_WIDTH x IMAGE_HEIGHT source. A new coordinate is taken every clock
// unless the output is stalled; each result passes through the 48-stage
// restoring divider for the focal-length normalization followed by six rounds
// of three-stage fixed-point multipliers. Downstream backpressure freezes the
// whole pipeline. Coefficients and geometry are written through the cfg port;
// the user must write them only while the block is idle, as it does not enforce this.
module lens_distortion_remap #(
    parameter int IMAGE_WIDTH  = 800,
    parameter int IMAGE_HEIGHT = 600
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [11:0] out_col,
    input  logic [11:0] out_row,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [11:0] src_col,
    output logic [11:0] src_row,
    output logic        in_bounds
);
    import ldr_pkg::*;

    localparam int LAT = 74;

    logic signed [31:0] k1_reg, k2_reg, k3_reg, p1_reg, p2_reg;
    logic [19:0]        fx_reg, fy_reg;
    logic [23:0]        pp_reg;

    logic [19:0] fxe, fye;
    logic [11:0] ccol, crow;
    q_t          fxq, fyq, ccolq, crowq;
    q_t          k1q, k2q, k3q, p1q, p2q;

    logic           en;
    logic [LAT-1:0] valid_reg;

    logic signed [12:0] dcol, drow;
    logic [11:0] magx_reg, magy_reg;
    logic        negx_reg, negy_reg;

    logic [47:0] qx, qy;
    logic        qxn, qyn;

    q_t x_reg, y_reg;
    q_t x2_w, y2_w, xy_w;
    q_t r2b_reg, x2d_reg, y2d_reg, xyb_reg;
    q_t ax_reg, ay_reg, r2c_reg, xyc_reg;
    q_t r4_w, k1r2_w, t1_w, t2_w, mx_w, my_w;
    q_t r2dl_reg [3];
    q_t r6_w, k2r4_w, k3r6_w;
    q_t a1_reg, a1b_reg, a1c_reg, tt1_reg, tt2_reg, mxe_reg, mye_reg;
    q_t xt_reg, yt_reg;
    q_t a2_reg, a2b_reg, a2c_reg, radial_reg;
    q_t xdl_reg [15];
    q_t ydl_reg [15];
    q_t xtdl_reg [8];
    q_t ytdl_reg [8];
    q_t xr_w, yr_w, xd_reg, yd_reg, px_w, py_w, pc_reg, pr_reg;

    logic        col_ok, row_ok;
    logic [11:0] src_col_reg, src_row_reg;
    logic        in_bounds_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k1_reg <= -32'sd80530637;
            k2_reg <= 32'sd26843546;
            k3_reg <= '0;
            p1_reg <= '0;
            p2_reg <= '0;
            fx_reg <= 20'd204800;
            fy_reg <= 20'd204800;
            pp_reg <= 24'd1638700;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                REG_K1:  k1_reg <= cfg_wdata;
                REG_K2:  k2_reg <= cfg_wdata;
                REG_K3:  k3_reg <= cfg_wdata;
                REG_P1:  p1_reg <= cfg_wdata;
                REG_P2:  p2_reg <= cfg_wdata;
                REG_FX:  fx_reg <= cfg_wdata[19:0];
                REG_FY:  fy_reg <= cfg_wdata[19:0];
                REG_PP:  pp_reg <= cfg_wdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        fxe   = (fx_reg == '0) ? 20'd1 : fx_reg;
        fye   = (fy_reg == '0) ? 20'd1 : fy_reg;
        ccol  = pp_reg[23:12];
        crow  = pp_reg[11:0];
        fxq   = q_t'({11'd0, fxe, 20'd0});
        fyq   = q_t'({11'd0, fye, 20'd0});
        ccolq = q_t'({11'd0, ccol, 28'd0});
        crowq = q_t'({11'd0, crow, 28'd0});
        k1q   = q_t'(k1_reg);
        k2q   = q_t'(k2_reg);
        k3q   = q_t'(k3_reg);
        p1q   = q_t'(p1_reg);
        p2q   = q_t'(p2_reg);
        dcol  = $signed({1'b0, out_col}) - $signed({1'b0, ccol});
        drow  = $signed({1'b0, out_row}) - $signed({1'b0, crow});
    end

    assign en = !valid_reg[LAT-1] || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[LAT-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            negx_reg <= dcol[12];
            negy_reg <= drow[12];
            magx_reg <= dcol[12] ? 12'(-dcol) : dcol[11:0];
            magy_reg <= drow[12] ? 12'(-drow) : drow[11:0];
        end
    end

    ldr_div u_div_x (
        .clk(clk), .en(en), .mag(magx_reg), .neg(negx_reg), .divisor(fxe),
        .quot(qx), .quot_neg(qxn)
    );

    ldr_div u_div_y (
        .clk(clk), .en(en), .mag(magy_reg), .neg(negy_reg), .divisor(fye),
        .quot(qy), .quot_neg(qyn)
    );

    ldr_mul u_mul_x2 (.clk(clk), .en(en), .a(x_reg), .b(x_reg), .p(x2_w));
    ldr_mul u_mul_y2 (.clk(clk), .en(en), .a(y_reg), .b(y_reg), .p(y2_w));
    ldr_mul u_mul_xy (.clk(clk), .en(en), .a(x_reg), .b(y_reg), .p(xy_w));

    ldr_mul u_mul_r4   (.clk(clk), .en(en), .a(r2c_reg), .b(r2c_reg), .p(r4_w));
    ldr_mul u_mul_k1r2 (.clk(clk), .en(en), .a(k1q), .b(r2c_reg), .p(k1r2_w));
    ldr_mul u_mul_t1   (.clk(clk), .en(en), .a(p1q), .b(xyc_reg), .p(t1_w));
    ldr_mul u_mul_t2   (.clk(clk), .en(en), .a(p2q), .b(xyc_reg), .p(t2_w));
    ldr_mul u_mul_mx   (.clk(clk), .en(en), .a(p2q), .b(ax_reg), .p(mx_w));
    ldr_mul u_mul_my   (.clk(clk), .en(en), .a(p1q), .b(ay_reg), .p(my_w));

    ldr_mul u_mul_r6   (.clk(clk), .en(en), .a(r4_w), .b(r2dl_reg[2]), .p(r6_w));
    ldr_mul u_mul_k2r4 (.clk(clk), .en(en), .a(k2q), .b(r4_w), .p(k2r4_w));
    ldr_mul u_mul_k3r6 (.clk(clk), .en(en), .a(k3q), .b(r6_w), .p(k3r6_w));

    ldr_mul u_mul_xr (.clk(clk), .en(en), .a(xdl_reg[14]), .b(radial_reg), .p(xr_w));
    ldr_mul u_mul_yr (.clk(clk), .en(en), .a(ydl_reg[14]), .b(radial_reg), .p(yr_w));

    ldr_mul u_mul_px (.clk(clk), .en(en), .a(xd_reg), .b(fxq), .p(px_w));
    ldr_mul u_mul_py (.clk(clk), .en(en), .a(yd_reg), .b(fyq), .p(py_w));

    always_comb
    begin
        col_ok = !pc_reg[QW-1] && (23'(pc_reg[QW-1:FRAC_BITS]) < 23'(IMAGE_WIDTH));
        row_ok = !pr_reg[QW-1] && (23'(pr_reg[QW-1:FRAC_BITS]) < 23'(IMAGE_HEIGHT));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= qxn ? -q_t'({3'd0, qx}) : q_t'({3'd0, qx});
            y_reg <= qyn ? -q_t'({3'd0, qy}) : q_t'({3'd0, qy});

            r2b_reg <= sat_add(x2_w, y2_w);
            x2d_reg <= sat_add(x2_w, x2_w);
            y2d_reg <= sat_add(y2_w, y2_w);
            xyb_reg <= xy_w;

            ax_reg  <= sat_add(r2b_reg, x2d_reg);
            ay_reg  <= sat_add(r2b_reg, y2d_reg);
            r2c_reg <= r2b_reg;
            xyc_reg <= xyb_reg;

            r2dl_reg[0] <= r2c_reg;
            r2dl_reg[1] <= r2dl_reg[0];
            r2dl_reg[2] <= r2dl_reg[1];

            a1_reg  <= sat_add(ONE_Q, k1r2_w);
            tt1_reg <= sat_add(t1_w, t1_w);
            tt2_reg <= sat_add(t2_w, t2_w);
            mxe_reg <= mx_w;
            mye_reg <= my_w;

            xt_reg  <= sat_add(tt1_reg, mxe_reg);
            yt_reg  <= sat_add(mye_reg, tt2_reg);
            a1b_reg <= a1_reg;
            a1c_reg <= a1b_reg;

            a2_reg     <= sat_add(a1c_reg, k2r4_w);
            a2b_reg    <= a2_reg;
            a2c_reg    <= a2b_reg;
            radial_reg <= sat_add(a2c_reg, k3r6_w);

            xdl_reg[0] <= x_reg;
            ydl_reg[0] <= y_reg;
            for (int i = 1; i < 15; i++)
            begin
                xdl_reg[i] <= xdl_reg[i-1];
                ydl_reg[i] <= ydl_reg[i-1];
            end
            xtdl_reg[0] <= xt_reg;
            ytdl_reg[0] <= yt_reg;
            for (int i = 1; i < 8; i++)
            begin
                xtdl_reg[i] <= xtdl_reg[i-1];
                ytdl_reg[i] <= ytdl_reg[i-1];
            end

            xd_reg <= sat_add(xr_w, xtdl_reg[7]);
            yd_reg <= sat_add(yr_w, ytdl_reg[7]);

            pc_reg <= sat_add(px_w, ccolq);
            pr_reg <= sat_add(py_w, crowq);

            in_bounds_reg <= col_ok && row_ok;
            src_col_reg   <= (col_ok && row_ok) ? pc_reg[FRAC_BITS+11:FRAC_BITS] : 12'd0;
            src_row_reg   <= (col_ok && row_ok) ? pr_reg[FRAC_BITS+11:FRAC_BITS] : 12'd0;
        end
    end

    assign out_valid = valid_reg[LAT-1];
    assign src_col   = src_col_reg;
    assign src_row   = src_row_reg;
    assign in_bounds = in_bounds_reg;

`ifndef ASSERT_OFF
    a_oob_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !in_bounds |-> src_col == 12'd0 && src_row == 12'd0)
        else $error("out-of-bounds beat carries nonzero indices");

    a_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && in_bounds |->
            ({1'b0, src_col} < 13'(IMAGE_WIDTH)) && ({1'b0, src_row} < 13'(IMAGE_HEIGHT)))
        else $error("in-bounds beat outside source image");

    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("pipeline advances while output stalled");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(valid_reg))
        else $error("pipeline valid bits moved during stall");
`endif

endmodule
